/* design/sfc_pkg.sv */
// ----------------------------------------------------------------------------
// sfc_pkg: shared types, constants and functions for the flow cookie hash
// SipHash-2-4 constants, the round function and the microcode program ROM.
// ----------------------------------------------------------------------------
package sfc_pkg;

	// SipHash state: v[0]..v[3]
	typedef logic [3:0][63:0] sip_state_t;

	localparam logic [63:0] IV0 = 64'h736f6d6570736575;
	localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
	localparam logic [63:0] IV2 = 64'h6c7967656e657261;
	localparam logic [63:0] IV3 = 64'h7465646279746573;

	// Finalization constant xored into v2
	localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

	// Message lengths in bytes
	localparam logic [7:0] LEN_V4 = 8'd12;
	localparam logic [7:0] LEN_V6 = 8'd36;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	// Message word selects
	typedef enum logic [2:0] {
		MSG_NONE,
		MSG_FIRST,   // IPv6 source upper, or both IPv4 addresses
		MSG_SL,
		MSG_DU,
		MSG_DL,
		MSG_FIN      // ports plus length byte
	} msel_t;

	// One microcode control word
	typedef struct packed {
		msel_t msel;
		logic  pre_xor;   // v3 ^= m before the round
		logic  post_xor;  // v0 ^= m after the round
		logic  fin_xor;   // v2 ^= 0xff before the round
		logic  jmp_v4;    // jump to jmp_tgt when the flow is IPv4
		pc_t   jmp_tgt;
		logic  last;      // final round, hash is ready
	} cw_t;

	localparam pc_t PC_FIN = 4'd8;

	// Program: two rounds per message block, four finalization rounds
	function automatic cw_t prog_rom(input pc_t pc);
		cw_t cw;
		cw = '{msel: MSG_NONE, pre_xor: 1'b0, post_xor: 1'b0, fin_xor: 1'b0,
			jmp_v4: 1'b0, jmp_tgt: '0, last: 1'b0};
		unique case (pc)
			4'd0: begin cw.msel = MSG_FIRST; cw.pre_xor = 1'b1; end
			4'd1: begin
				cw.msel = MSG_FIRST; cw.post_xor = 1'b1;
				cw.jmp_v4 = 1'b1; cw.jmp_tgt = PC_FIN;
			end
			4'd2: begin cw.msel = MSG_SL; cw.pre_xor = 1'b1; end
			4'd3: begin cw.msel = MSG_SL; cw.post_xor = 1'b1; end
			4'd4: begin cw.msel = MSG_DU; cw.pre_xor = 1'b1; end
			4'd5: begin cw.msel = MSG_DU; cw.post_xor = 1'b1; end
			4'd6: begin cw.msel = MSG_DL; cw.pre_xor = 1'b1; end
			4'd7: begin cw.msel = MSG_DL; cw.post_xor = 1'b1; end
			4'd8: begin cw.msel = MSG_FIN; cw.pre_xor = 1'b1; end
			4'd9: begin cw.msel = MSG_FIN; cw.post_xor = 1'b1; end
			4'd10: cw.fin_xor = 1'b1;
			4'd11: ;
			4'd12: ;
			4'd13: cw.last = 1'b1;
			default: cw.last = 1'b1;  // unused steps end the program
		endcase
		return cw;
	endfunction

	function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned b);
		return (x << b) | (x >> (64 - b));
	endfunction

	// One SipRound
	function automatic sip_state_t sip_round(input sip_state_t vi);
		sip_state_t v;
		v = vi;
		v[0] = v[0] + v[1]; v[1] = rotl(v[1], 13); v[1] = v[1] ^ v[0];
		v[0] = rotl(v[0], 32);
		v[2] = v[2] + v[3]; v[3] = rotl(v[3], 16); v[3] = v[3] ^ v[2];
		v[0] = v[0] + v[3]; v[3] = rotl(v[3], 21); v[3] = v[3] ^ v[0];
		v[2] = v[2] + v[1]; v[1] = rotl(v[1], 17); v[1] = v[1] ^ v[2];
		v[2] = rotl(v[2], 32);
		return v;
	endfunction

	// Wire bytes (first byte in the top) to a little-endian message word
	function automatic logic [63:0] bswap64(input logic [63:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24],
			x[39:32], x[47:40], x[55:48], x[63:56]};
	endfunction

endpackage

/* design/siphash_flow_cookie.sv */
// ----------------------------------------------------------------------------
// siphash_flow_cookie: SipHash-2-4 cookie over a UDP flow
// Microcoded engine: a step counter walks a program ROM, one round per step.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------------------
//  request  | start / busy      | key_low, key_high, is_ipv6, addresses, ports
//  result   | done (one cycle)  | cookie
//
// A transaction is taken at an edge with start high and busy low.
// IPv4 flows run 8 steps, IPv6 flows 14 steps: one SipRound per step on a
// single round datapath; done is registered in the cycle after the last step.
// busy drops during the last step, so a new transaction can be taken then.
// Reset clears the sequencer; the receiver cannot stall the result.
module siphash_flow_cookie
	import sfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] key_low,
	input  logic [63:0] key_high,
	input  logic        is_ipv6,
	input  logic [63:0] src_addr_upper,
	input  logic [63:0] src_addr_lower,
	input  logic [63:0] dst_addr_upper,
	input  logic [63:0] dst_addr_lower,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	output logic        done,
	output logic [63:0] cookie
);

	logic        busy_q;
	pc_t         pc_q;
	logic        done_q;
	logic [63:0] cookie_q;
	sip_state_t  v_q;

	// captured flow fields
	logic        v6_q;
	logic [63:0] su_q, sl_q, du_q, dl_q;
	logic [15:0] sp_q, dp_q;

	cw_t         cw;
	logic        accept;
	logic [63:0] msg;
	logic [7:0]  len;
	sip_state_t  v_pre, v_rnd, v_nxt;
	pc_t         pc_nxt;

	// control word for the current step
	assign cw     = prog_rom(pc_q);
	assign busy   = busy_q && !cw.last;
	assign accept = start && !busy;

	// message word select
	assign len = v6_q ? LEN_V6 : LEN_V4;
	always_comb begin
		case (cw.msel)
			MSG_FIRST: msg = v6_q ? bswap64(su_q) : bswap64({sl_q[31:0], dl_q[31:0]});
			MSG_SL:    msg = bswap64(sl_q);
			MSG_DU:    msg = bswap64(du_q);
			MSG_DL:    msg = bswap64(dl_q);
			MSG_FIN:   msg = {len, 24'h0, dp_q[7:0], dp_q[15:8], sp_q[7:0], sp_q[15:8]};
			default:   msg = '0;
		endcase
	end

	// round datapath: optional pre-xor, one SipRound, optional post-xor
	always_comb begin
		v_pre = v_q;
		if (cw.pre_xor) begin
			v_pre[3] = v_pre[3] ^ msg;
		end
		if (cw.fin_xor) begin
			v_pre[2] = v_pre[2] ^ FIN_XOR;
		end
		v_rnd = sip_round(v_pre);
		v_nxt = v_rnd;
		if (cw.post_xor) begin
			v_nxt[0] = v_nxt[0] ^ msg;
		end
	end

	// next step: conditional jump for IPv4 flows
	always_comb begin
		if (cw.last) begin
			pc_nxt = '0;
		end else if (cw.jmp_v4 && !v6_q) begin
			pc_nxt = cw.jmp_tgt;
		end else begin
			pc_nxt = pc_q + 1'b1;
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && cw.last;
			if (accept) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end else if (busy_q) begin
				busy_q <= !cw.last;
				pc_q   <= pc_nxt;
			end
		end
	end

	// state, captured fields and result
	always_ff @(posedge clk) begin
		if (busy_q && cw.last) begin
			cookie_q <= v_nxt[0] ^ v_nxt[1] ^ v_nxt[2] ^ v_nxt[3];
		end
		if (accept) begin
			v_q[0] <= key_low ^ IV0;
			v_q[1] <= key_high ^ IV1;
			v_q[2] <= key_low ^ IV2;
			v_q[3] <= key_high ^ IV3;
			v6_q   <= is_ipv6;
			su_q   <= src_addr_upper;
			sl_q   <= src_addr_lower;
			du_q   <= dst_addr_upper;
			dl_q   <= dst_addr_lower;
			sp_q   <= src_port;
			dp_q   <= dst_port;
		end else if (busy_q) begin
			v_q <= v_nxt;
		end
	end

	assign done   = done_q;
	assign cookie = cookie_q;

	// a transaction starts the program at step zero
	a_start_pc: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && (pc_q == '0))
		else $error("transaction did not start program at step zero");

	// a result follows only the final step
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy_q && cw.last))
		else $error("result without final step");

	// a result is never followed directly by another
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back results");

	// the step counter stays inside the program
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q <= 4'd13))
		else $error("step counter left the program");

	// an idle sequencer sits at step zero
	a_idle_pc: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (pc_q == '0))
		else $error("idle sequencer not at step zero");

endmodule
